### design/mtl_pkg.sv
// ----------------------------------------------------------------------------
// mtl_pkg: shared types and constants for the markup text layout block
// Item and result formats, parser commands, tag codes and cursor helpers.
// ----------------------------------------------------------------------------
package mtl_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned ODEPTH = 2;
  localparam int unsigned OAW    = $clog2(ODEPTH);

  localparam logic [11:0] X_HOME      = 12'd40;
  localparam logic [15:0] Y_HOME      = 16'd50;
  localparam logic [11:0] WRAP_MARGIN = 12'd40;
  localparam logic [15:0] BOT_MARGIN  = 16'd20;
  localparam logic [4:0]  LINE_STEP   = 5'd18;
  localparam logic [4:0]  H1_OPEN_DY  = 5'd10;
  localparam logic [4:0]  H1_CLOSE_DY = 5'd24;
  localparam logic [4:0]  H2_OPEN_DY  = 5'd6;
  localparam logic [4:0]  H2_CLOSE_DY = 5'd22;
  localparam logic [4:0]  P_OPEN_DY   = 5'd8;
  localparam logic [4:0]  P_CLOSE_DY  = 5'd20;
  localparam logic [3:0]  ADV_NORMAL  = 4'd8;
  localparam logic [3:0]  ADV_LARGE   = 4'd11;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LR    = 8'h72;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    COL_TEXT = 3'd0,
    COL_H1   = 3'd1,
    COL_H2   = 3'd2,
    COL_LINK = 3'd3,
    COL_BOLD = 3'd4
  } color_t;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_OPEN = 2'd1,
    MODE_NAME = 2'd2,
    MODE_SKIP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_GLYPH = 3'd1,
    OP_TAG   = 3'd2,
    OP_CHECK = 3'd3,
    OP_HALT  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    TAG_NONE = 3'd0,
    TAG_H1   = 3'd1,
    TAG_H2   = 3'd2,
    TAG_P    = 3'd3,
    TAG_B    = 3'd4,
    TAG_A    = 3'd5,
    TAG_LI   = 3'd6,
    TAG_BR   = 3'd7
  } tag_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  glyph;
    logic [2:0]  color_code;
    logic        large_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    tag_t       tag;
    logic       closing;
    logic       check;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [15:0] sat_add(input logic [15:0] y, input logic [4:0] dy);
    logic [16:0] s;
    s = {1'b0, y} + {12'd0, dy};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic past_bottom(input logic [15:0] y, input logic [11:0] height);
    return ({1'b0, y} + {1'b0, BOT_MARGIN}) > {5'd0, height};
  endfunction

endpackage

### design/mtl_front.sv
// ----------------------------------------------------------------------------
// mtl_front: markup parser front end
// Tracks tag syntax per character and issues layout commands to the queue.
// ----------------------------------------------------------------------------
module mtl_front
  import mtl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     cmd_push,
  output cmd_t     cmd
);

  mode_t      mode_r, mode_nxt;
  logic       closing_r, closing_nxt;
  logic [7:0] name0_r, name0_nxt;
  logic [7:0] name1_r, name1_nxt;
  logic [1:0] nlen_r, nlen_nxt;
  logic       pend_r, pend_nxt;

  logic [7:0] c;
  logic [7:0] c_low;
  logic       is_term;
  tag_t       tag_id;

  assign c       = item.char_code;
  assign c_low   = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
  assign is_term = (c == CH_GT) || (c == CH_SPACE) || (c == CH_SLASH);

  always_comb begin
    tag_id = TAG_NONE;
    if (nlen_r == 2'd1) begin
      if (name0_r == CH_LP) tag_id = TAG_P;
      else if (name0_r == CH_LB) tag_id = TAG_B;
      else if (name0_r == CH_LA) tag_id = TAG_A;
    end else if (nlen_r == 2'd2) begin
      if (name0_r == CH_LH && name1_r == CH_1) tag_id = TAG_H1;
      else if (name0_r == CH_LH && name1_r == CH_2) tag_id = TAG_H2;
      else if (name0_r == CH_LL && name1_r == CH_LI) tag_id = TAG_LI;
      else if (name0_r == CH_LB && name1_r == CH_LR) tag_id = TAG_BR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TEXT;
      closing_r <= 1'b0;
      name0_r   <= '0;
      name1_r   <= '0;
      nlen_r    <= '0;
      pend_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      closing_r <= closing_nxt;
      name0_r   <= name0_nxt;
      name1_r   <= name1_nxt;
      nlen_r    <= nlen_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    closing_nxt = closing_r;
    name0_nxt   = name0_r;
    name1_nxt   = name1_r;
    nlen_nxt    = nlen_r;
    pend_nxt    = pend_r;
    cmd_push    = 1'b0;
    cmd.op      = OP_START;
    cmd.tag     = tag_id;
    cmd.closing = closing_r;
    cmd.check   = 1'b0;
    cmd.ch      = c;
    if (accept) begin
      if (!item.kind) begin
        cmd_push    = 1'b1;
        cmd.op      = OP_START;
        mode_nxt    = MODE_TEXT;
        closing_nxt = 1'b0;
        name0_nxt   = '0;
        name1_nxt   = '0;
        nlen_nxt    = '0;
        pend_nxt    = 1'b0;
      end else if (c == CH_NUL) begin
        cmd_push = 1'b1;
        cmd.op   = OP_HALT;
      end else begin
        unique case (mode_r)
          MODE_TEXT: begin
            if (c == CH_LT) begin
              cmd_push    = pend_r;
              cmd.op      = OP_CHECK;
              pend_nxt    = 1'b0;
              mode_nxt    = MODE_OPEN;
              closing_nxt = 1'b0;
              nlen_nxt    = '0;
              name0_nxt   = '0;
              name1_nxt   = '0;
            end else begin
              cmd_push = 1'b1;
              cmd.op   = OP_GLYPH;
              cmd.ch   = (c == CH_NL || c == CH_TAB) ? CH_SPACE : c;
              pend_nxt = 1'b1;
            end
          end
          MODE_SKIP: begin
            if (c == CH_GT) begin
              cmd_push = 1'b1;
              cmd.op   = OP_CHECK;
              mode_nxt = MODE_TEXT;
            end
          end
          MODE_OPEN, MODE_NAME: begin
            if (mode_r == MODE_OPEN && c == CH_SLASH) begin
              closing_nxt = 1'b1;
              mode_nxt    = MODE_NAME;
            end else if (is_term) begin
              cmd_push  = 1'b1;
              cmd.op    = OP_TAG;
              cmd.check = (c == CH_GT);
              mode_nxt  = (c == CH_GT) ? MODE_TEXT : MODE_SKIP;
            end else begin
              if (nlen_r == 2'd0) name0_nxt = c_low;
              if (nlen_r == 2'd1) name1_nxt = c_low;
              if (nlen_r != 2'd3) nlen_nxt = nlen_r + 2'd1;
              mode_nxt = MODE_NAME;
            end
          end
          default: mode_nxt = MODE_TEXT;
        endcase
      end
    end
  end

endmodule

### design/mtl_cmd_queue.sv
// ----------------------------------------------------------------------------
// mtl_cmd_queue: command queue between parser and layout engine
// Small first-in first-out store that decouples the two sides.
// ----------------------------------------------------------------------------
module mtl_cmd_queue
  import mtl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t             mem [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r] <= din;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) wp_nxt = wp_r + 1'b1;
    if (pop && !empty) rp_nxt = rp_r + 1'b1;
    if ((push && !full) && !(pop && !empty)) cnt_nxt = cnt_r + 1'b1;
    else if (!(push && !full) && (pop && !empty)) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/mtl_back.sv
// ----------------------------------------------------------------------------
// mtl_back: layout engine
// Executes parser commands on the cursor and style state, emits glyphs.
// ----------------------------------------------------------------------------
module mtl_back
  import mtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] screen_width,
  input  logic [11:0] screen_height,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_res
);

  logic [11:0] cx_r, cx_nxt;
  logic [15:0] cy_r, cy_nxt;
  color_t      color_r, color_nxt;
  logic        big_r, big_nxt;
  logic        bold_r, bold_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  li_cnt_r, li_cnt_nxt;

  out_item_t       ob_mem [ODEPTH];
  logic [OAW-1:0]  ob_wp_r, ob_rp_r;
  logic [OAW:0]    ob_cnt_r;
  logic            ob_full;
  logic            ob_push;
  logic            ob_pop;

  logic        proceed;
  logic        done;
  logic        emit;
  logic        last;
  logic [7:0]  gch;
  logic        is_li;
  logic        chk_now;
  logic [4:0]  dy;
  logic        to_home;
  logic [15:0] y_tag;
  logic [11:0] gx_in;
  logic [15:0] gy_in;
  logic        wrap;
  logic [11:0] px;
  logic [15:0] py;
  out_item_t   res;

  assign ob_full = (ob_cnt_r == (OAW+1)'(ODEPTH));
  assign proceed = !q_empty && !ob_full;
  assign is_li   = (q_head.op == OP_TAG) && (q_head.tag == TAG_LI) && !q_head.closing
                   && !stop_r;
  assign done    = !is_li || (li_cnt_r == 2'd3);
  assign q_pop   = proceed && done;
  assign ob_push = proceed && emit;
  assign ob_pop  = out_pop && !out_empty;

  always_comb begin
    dy      = '0;
    to_home = 1'b0;
    case (q_head.tag)
      TAG_H1: begin
        to_home = 1'b1;
        dy      = q_head.closing ? H1_CLOSE_DY : ((cy_r > Y_HOME) ? H1_OPEN_DY : 5'd0);
      end
      TAG_H2: begin
        to_home = 1'b1;
        dy      = q_head.closing ? H2_CLOSE_DY : H2_OPEN_DY;
      end
      TAG_P: begin
        to_home = 1'b1;
        dy      = q_head.closing ? P_CLOSE_DY : P_OPEN_DY;
      end
      TAG_LI: begin
        to_home = !q_head.closing;
        dy      = q_head.closing ? 5'd0 : LINE_STEP;
      end
      TAG_BR: begin
        to_home = 1'b1;
        dy      = LINE_STEP;
      end
      default: begin
        to_home = 1'b0;
        dy      = '0;
      end
    endcase
  end

  assign y_tag = sat_add(cy_r, dy);
  assign gx_in = (is_li && li_cnt_r == 2'd0) ? X_HOME : cx_r;
  assign gy_in = (is_li && li_cnt_r == 2'd0) ? y_tag : cy_r;
  assign wrap  = ({1'b0, gx_in} + {1'b0, WRAP_MARGIN}) > {1'b0, screen_width};
  assign px    = wrap ? X_HOME : gx_in;
  assign py    = wrap ? sat_add(gy_in, LINE_STEP) : gy_in;

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    big_nxt    = big_r;
    bold_nxt   = bold_r;
    stop_nxt   = stop_r;
    li_cnt_nxt = li_cnt_r;
    emit       = 1'b0;
    last       = 1'b0;
    gch        = q_head.ch;
    chk_now    = 1'b0;
    if (proceed) begin
      unique case (q_head.op)
        OP_START: begin
          cx_nxt     = X_HOME;
          cy_nxt     = Y_HOME;
          color_nxt  = COL_TEXT;
          big_nxt    = 1'b0;
          bold_nxt   = 1'b0;
          stop_nxt   = 1'b0;
          li_cnt_nxt = '0;
        end
        OP_HALT: stop_nxt = 1'b1;
        OP_CHECK: chk_now = !stop_r;
        OP_GLYPH: begin
          if (!stop_r) begin
            emit   = 1'b1;
            last   = 1'b1;
            cx_nxt = px + (big_r ? 12'(ADV_LARGE) : 12'(ADV_NORMAL));
            cy_nxt = py;
          end
        end
        OP_TAG: begin
          if (is_li) begin
            emit       = 1'b1;
            last       = (li_cnt_r == 2'd3);
            gch        = (li_cnt_r == 2'd2) ? CH_DASH : CH_SPACE;
            cx_nxt     = px + (big_r ? 12'(ADV_LARGE) : 12'(ADV_NORMAL));
            cy_nxt     = py;
            li_cnt_nxt = li_cnt_r + 2'd1;
            chk_now    = (li_cnt_r == 2'd3) && q_head.check;
          end else if (!stop_r) begin
            chk_now = q_head.check;
            if (to_home) cx_nxt = X_HOME;
            cy_nxt = y_tag;
            case (q_head.tag)
              TAG_H1: begin
                big_nxt   = !q_head.closing;
                color_nxt = q_head.closing ? COL_TEXT : COL_H1;
              end
              TAG_H2: begin
                big_nxt   = !q_head.closing;
                color_nxt = q_head.closing ? COL_TEXT : COL_H2;
              end
              TAG_B: bold_nxt = !q_head.closing;
              TAG_A: color_nxt = q_head.closing ? COL_TEXT : COL_LINK;
              default: bold_nxt = bold_r;
            endcase
          end
        end
        default: stop_nxt = stop_r;
      endcase
      if (chk_now && past_bottom(cy_nxt, screen_height)) stop_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= X_HOME;
      cy_r     <= Y_HOME;
      color_r  <= COL_TEXT;
      big_r    <= 1'b0;
      bold_r   <= 1'b0;
      stop_r   <= 1'b0;
      li_cnt_r <= '0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      big_r    <= big_nxt;
      bold_r   <= bold_nxt;
      stop_r   <= stop_nxt;
      li_cnt_r <= li_cnt_nxt;
    end
  end

  always_comb begin
    res.pos_x      = px;
    res.pos_y      = py;
    res.glyph      = gch;
    res.color_code = bold_r ? COL_BOLD : color_r;
    res.large_res  = big_r;
    res.last       = last;
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_mem[ob_wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= '0;
      ob_rp_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (ob_push) ob_wp_r <= ob_wp_r + 1'b1;
      if (ob_pop) ob_rp_r <= ob_rp_r + 1'b1;
      if (ob_push && !ob_pop) ob_cnt_r <= ob_cnt_r + 1'b1;
      else if (!ob_push && ob_pop) ob_cnt_r <= ob_cnt_r - 1'b1;
    end
  end

  assign out_empty = (ob_cnt_r == '0);
  assign out_res   = ob_mem[ob_rp_r];

  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= (OAW+1)'(ODEPTH))
    else $error("result buffer overflow");

  a_li_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (li_cnt_r != 2'd0) |-> (!q_empty && q_head.op == OP_TAG && q_head.tag == TAG_LI
                            && !q_head.closing))
    else $error("list burst lost its command");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && q_head.op == OP_START) |=> (!stop_r && cx_r == X_HOME && cy_r == Y_HOME))
    else $error("start did not restore layout");

  a_no_emit_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> !stop_r)
    else $error("glyph emitted while stopped");

endmodule

### design/markup_text_layout.sv
// ----------------------------------------------------------------------------
// markup_text_layout: markup document to glyph placement commands
// Parses tags and text one byte at a time and places glyphs on screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item and raise in_push; the item transfers on a
//   clock edge with in_push high and in_full low. kind 0 starts a document,
//   kind 1 carries one byte. One item is taken every cycle while the command
//   queue has room.
//   Result queue: while out_empty is low, out_res holds the oldest glyph; it
//   transfers on a clock edge with out_pop high. A text byte gives one glyph,
//   an opening li tag four glyphs; other bytes give none.
//   A byte's command passes the command queue, its glyph the result buffer.
//   Throughput: one byte per cycle while the command queue has room; the
//   layout engine emits at most one glyph per cycle, so each li tag holds the
//   command queue. Stalls: with out_pop low the two-entry result buffer fills,
//   the engine holds, the four-entry command queue fills and in_full rises.
//   Configuration: cfg_index 0 is screen width, 1 is screen height; writes
//   are always taken. Reset sets 1024 by 768, empties both queues and puts
//   the cursor at home.
// ----------------------------------------------------------------------------
module markup_text_layout
  import mtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [11:0] width_r;
  logic [11:0] height_r;
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd;
  logic        q_pop;
  logic        q_empty;
  cmd_t        q_head;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd1024;
      height_r <= 12'd768;
    end else if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
      if (cfg_index[0] == REG_SCREEN_WIDTH) width_r <= cfg_data;
      if (cfg_index[0] == REG_SCREEN_HEIGHT) height_r <= cfg_data;
    end
  end

  mtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  mtl_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  mtl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (width_r),
    .screen_height (height_r),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_res       (out_res)
  );

endmodule
